### rtl/core/pvr_pkg.sv
// ----------------------------------------------------------------------------
// pvr_pkg: shared types and constants for the polygon vertex unit
// Request and status codes, the iterative unit's command and status, and
// fixed widths of the vertex and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

package pvr_pkg;

    localparam int COORD_W = 16;          // one coordinate, 4 fraction bits
    localparam int VTX_W   = 2 * COORD_W; // packed {x, y} in the store
    localparam int IDX_W   = 4;           // vertex_index field
    localparam int ANG_W   = 11;          // angle_deg field
    localparam int SQ_W    = 32;          // x*x + y*y
    localparam int ROOT_W  = 16;          // floored root and mean

    // a / 90 for 0 <= a < 1024 as (a * 1457) >> 17, exact over that range
    localparam int               ANG_PROD_W  = 21;
    localparam int               ANG_SHIFT   = 17;
    localparam logic [10:0]      ANG_RECIP   = 11'd1457;
    localparam logic [6:0]       QUARTER_DEG = 7'd90;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_ROTATE = 2'd1,
        REQ_MEAN   = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_BAD_ANGLE = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic     go;
        t_iter_op op;
    } t_iter_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage

`default_nettype wire

### rtl/core/polygon_vertex_rotate_mean_radius_unit.sv
// ----------------------------------------------------------------------------
// polygon_vertex_rotate_mean_radius_unit: vertex store, quarter-turn rotate,
// mean radius. The strobe rises as a request ends: add and every error at
// dispatch, read after the registered store read, rotate after the pivot
// read and a read and write-back per moved vertex (pivot skipped), mean
// after a 16-step root per vertex on the shared unit and a 21-step divide
// (16 + count width). A new beat is taken when the strobe cycle ends; the
// receiver cannot stall. Reset clears sequencer, strobe, vertex count only.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_vertex_rotate_mean_radius_unit #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic signed [15:0]              i_coord_x,
    input  logic signed [15:0]              i_coord_y,
    input  logic [3:0]                      i_vertex_index,
    input  logic signed [10:0]              i_angle_deg,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic signed [15:0]              o_out_x,
    output logic signed [15:0]              o_out_y,
    output logic [15:0]                     o_mean_radius,
    output logic [4:0]                      o_count_out
);

    // store address, vertex count and running sum of roots
    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int SW   = pvr_pkg::ROOT_W + CW;
    localparam int CMPW = (CW > pvr_pkg::IDX_W) ? CW : pvr_pkg::IDX_W;
    localparam int CRW  = pvr_pkg::COORD_W + 2; // room for px + py - y

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROT_PIV,
        S_ROT_PIVD,
        S_ROT_NEXT,
        S_ROT_RD,
        S_ROT_WR,
        S_MEAN_NEXT,
        S_MEAN_RD,
        S_MEAN_SQX,
        S_MEAN_SQY,
        S_SQRT_GO,
        S_SQRT_W,
        S_DIV_GO,
        S_DIV_W,
        S_READ_RD,
        S_READ_D
    } t_state;

    t_state                                r_state;
    pvr_pkg::t_req                         r_req;
    logic signed [pvr_pkg::COORD_W-1:0]    r_x;
    logic signed [pvr_pkg::COORD_W-1:0]    r_y;
    logic [pvr_pkg::IDX_W-1:0]             r_idx;
    logic signed [pvr_pkg::ANG_W-1:0]      r_angle;
    logic [CW-1:0]                         r_count;
    logic [CW-1:0]                         r_i;
    logic [IW-1:0]                         r_addr;
    logic [1:0]                            r_turns;
    logic signed [pvr_pkg::COORD_W-1:0]    r_px;
    logic signed [pvr_pkg::COORD_W-1:0]    r_py;
    logic [pvr_pkg::SQ_W-1:0]              r_sqx;
    logic [pvr_pkg::SQ_W-1:0]              r_sqy;
    logic [SW-1:0]                         r_sum;
    logic                                  r_valid;
    pvr_pkg::t_status                      r_status;
    logic signed [pvr_pkg::COORD_W-1:0]    r_out_x;
    logic signed [pvr_pkg::COORD_W-1:0]    r_out_y;
    logic [pvr_pkg::ROOT_W-1:0]            r_mean;

    // ------------------------------------------------------------------
    // Vertex store: {x, y} per entry, written by add and rotate
    // ------------------------------------------------------------------
    logic                                  ram_we;
    logic [IW-1:0]                         ram_waddr;
    logic [pvr_pkg::VTX_W-1:0]             ram_wdata;
    logic [pvr_pkg::VTX_W-1:0]             ram_rdata;
    logic signed [pvr_pkg::COORD_W-1:0]    rd_x;
    logic signed [pvr_pkg::COORD_W-1:0]    rd_y;

    pvr_ram #(
        .WIDTH (pvr_pkg::VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = signed'(ram_rdata[pvr_pkg::VTX_W-1:pvr_pkg::COORD_W]);
    assign rd_y = signed'(ram_rdata[pvr_pkg::COORD_W-1:0]);

    // ------------------------------------------------------------------
    // Request checks
    // ------------------------------------------------------------------
    logic                          accept;
    logic                          store_full;
    logic                          idx_ok;
    logic [pvr_pkg::ANG_W-2:0]     ang_mag;
    logic [pvr_pkg::ANG_PROD_W-1:0] ang_prod;
    logic [pvr_pkg::ANG_PROD_W-pvr_pkg::ANG_SHIFT-1:0] ang_q;
    logic [pvr_pkg::ANG_W-2:0]     ang_back;
    logic                          ang_bad;

    assign accept     = start && !busy;
    assign store_full = (r_count >= CW'(MAX_VERTICES));
    assign idx_ok     = (CMPW'(r_idx) < CMPW'(r_count));

    // angle must be non-negative and a whole multiple of 90 degrees;
    // a / 90 via reciprocal multiply, then check the remainder
    assign ang_mag  = r_angle[pvr_pkg::ANG_W-2:0];
    assign ang_prod = pvr_pkg::ANG_PROD_W'(ang_mag)
                    * pvr_pkg::ANG_PROD_W'(pvr_pkg::ANG_RECIP);
    assign ang_q    = ang_prod[pvr_pkg::ANG_PROD_W-1:pvr_pkg::ANG_SHIFT];
    assign ang_back = (pvr_pkg::ANG_W-1)'(ang_q)
                    * (pvr_pkg::ANG_W-1)'(pvr_pkg::QUARTER_DEG);
    assign ang_bad  = r_angle[pvr_pkg::ANG_W-1] || (ang_back != ang_mag);

    // ------------------------------------------------------------------
    // Rotation about the pivot, saturated to the coordinate range
    // ------------------------------------------------------------------
    function automatic logic signed [pvr_pkg::COORD_W-1:0] sat_coord(
        input logic signed [CRW-1:0] v
    );
        if (v > CRW'(32767)) begin
            return 16'sh7FFF;
        end else if (v < -CRW'(32768)) begin
            return 16'sh8000;
        end
        return v[pvr_pkg::COORD_W-1:0];
    endfunction

    logic signed [CRW-1:0] e_px;
    logic signed [CRW-1:0] e_py;
    logic signed [CRW-1:0] e_x;
    logic signed [CRW-1:0] e_y;
    logic signed [CRW-1:0] rot_x_w;
    logic signed [CRW-1:0] rot_y_w;
    logic signed [pvr_pkg::COORD_W-1:0] rot_x;
    logic signed [pvr_pkg::COORD_W-1:0] rot_y;

    assign e_px = CRW'(r_px);
    assign e_py = CRW'(r_py);
    assign e_x  = CRW'(rd_x);
    assign e_y  = CRW'(rd_y);

    always_comb begin
        case (r_turns)
            2'd1: begin
                rot_x_w = e_px + e_py - e_y;
                rot_y_w = e_py - e_px + e_x;
            end
            2'd2: begin
                rot_x_w = e_px + e_px - e_x;
                rot_y_w = e_py + e_py - e_y;
            end
            2'd3: begin
                rot_x_w = e_px - e_py + e_y;
                rot_y_w = e_py + e_px - e_x;
            end
            default: begin
                rot_x_w = e_x;
                rot_y_w = e_y;
            end
        endcase
    end

    assign rot_x = sat_coord(rot_x_w);
    assign rot_y = sat_coord(rot_y_w);

    // store write port: append on add, write back on rotate
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {rot_x, rot_y};
        if (r_state == S_DISPATCH && r_req == pvr_pkg::REQ_ADD && !store_full) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(r_count);
            ram_wdata = {r_x, r_y};
        end else if (r_state == S_ROT_WR) begin
            ram_we    = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared squarer: x*x in one state, y*y in the next
    // ------------------------------------------------------------------
    logic signed [pvr_pkg::COORD_W-1:0] sq_op;
    logic signed [pvr_pkg::SQ_W-1:0]    sq_prod;

    assign sq_op   = (r_state == S_MEAN_SQX) ? rd_x : rd_y;
    assign sq_prod = pvr_pkg::SQ_W'(sq_op) * pvr_pkg::SQ_W'(sq_op);

    // ------------------------------------------------------------------
    // Shared root / divide unit
    // ------------------------------------------------------------------
    pvr_pkg::t_iter_cmd          iter_cmd;
    pvr_pkg::t_iter_sts          iter_sts;
    logic [pvr_pkg::ROOT_W-1:0]  iter_res;
    logic [pvr_pkg::SQ_W-1:0]    radicand;

    assign radicand    = r_sqx + r_sqy;
    assign iter_cmd.go = (r_state == S_SQRT_GO) || (r_state == S_DIV_GO);
    assign iter_cmd.op = (r_state == S_DIV_GO) ? pvr_pkg::ITER_DIV : pvr_pkg::ITER_SQRT;

    pvr_iter_unit #(
        .DIV_W (SW),
        .DVS_W (CW)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (iter_cmd),
        .i_radicand (radicand),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_sts      (iter_sts),
        .o_result   (iter_res)
    );

    // ------------------------------------------------------------------
    // Sequencer and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // capture the beat and clear the result fields
                        r_req    <= pvr_pkg::t_req'(i_req_type);
                        r_x      <= i_coord_x;
                        r_y      <= i_coord_y;
                        r_idx    <= i_vertex_index;
                        r_angle  <= i_angle_deg;
                        r_status <= pvr_pkg::ST_OK;
                        r_out_x  <= '0;
                        r_out_y  <= '0;
                        r_mean   <= '0;
                        r_state  <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (r_req)
                        pvr_pkg::REQ_ADD: begin
                            if (store_full) begin
                                r_status <= pvr_pkg::ST_FULL;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        pvr_pkg::REQ_ROTATE: begin
                            // angle is checked before the pivot
                            if (ang_bad) begin
                                r_status <= pvr_pkg::ST_BAD_ANGLE;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (!idx_ok) begin
                                r_status <= pvr_pkg::ST_BAD_INDEX;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_turns <= ang_q[1:0];
                                r_addr  <= IW'(r_idx);
                                r_state <= S_ROT_PIV;
                            end
                        end
                        pvr_pkg::REQ_MEAN: begin
                            if (r_count == '0) begin
                                r_status <= pvr_pkg::ST_EMPTY;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_i     <= '0;
                                r_sum   <= '0;
                                r_state <= S_MEAN_NEXT;
                            end
                        end
                        pvr_pkg::REQ_READ: begin
                            if (!idx_ok) begin
                                r_status <= pvr_pkg::ST_BAD_INDEX;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_addr  <= IW'(r_idx);
                                r_state <= S_READ_RD;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_ROT_PIV: begin
                    r_state <= S_ROT_PIVD;
                end
                S_ROT_PIVD: begin
                    r_px    <= rd_x;
                    r_py    <= rd_y;
                    r_i     <= '0;
                    r_state <= S_ROT_NEXT;
                end
                S_ROT_NEXT: begin
                    // walk every held vertex, skip the pivot
                    if (r_i >= r_count) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (CMPW'(r_i) == CMPW'(r_idx)) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_addr  <= IW'(r_i);
                        r_state <= S_ROT_RD;
                    end
                end
                S_ROT_RD: begin
                    r_state <= S_ROT_WR;
                end
                S_ROT_WR: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= S_ROT_NEXT;
                end
                S_MEAN_NEXT: begin
                    if (r_i >= r_count) begin
                        r_state <= S_DIV_GO;
                    end else begin
                        r_addr  <= IW'(r_i);
                        r_state <= S_MEAN_RD;
                    end
                end
                S_MEAN_RD: begin
                    r_state <= S_MEAN_SQX;
                end
                S_MEAN_SQX: begin
                    r_sqx   <= unsigned'(sq_prod);
                    r_state <= S_MEAN_SQY;
                end
                S_MEAN_SQY: begin
                    r_sqy   <= unsigned'(sq_prod);
                    r_state <= S_SQRT_GO;
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_W;
                end
                S_SQRT_W: begin
                    if (iter_sts.done) begin
                        r_sum   <= r_sum + SW'(iter_res);
                        r_i     <= r_i + CW'(1);
                        r_state <= S_MEAN_NEXT;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_W;
                end
                S_DIV_W: begin
                    if (iter_sts.done) begin
                        r_mean  <= iter_res;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_READ_RD: begin
                    r_state <= S_READ_D;
                end
                S_READ_D: begin
                    r_out_x <= rd_x;
                    r_out_y <= rd_y;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_mean_radius = r_mean;
    assign o_count_out   = 5'(r_count);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a result beat lasts one cycle and the block is free while it shows
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy ##1 !o_valid)
        else $error("result strobe held or shown while busy");

    // the store never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // an accepted beat always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted beat did not start work");

    // the shared unit finishes only while the sequencer waits for it
    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_sts.done |-> (r_state == S_SQRT_W || r_state == S_DIV_W))
        else $error("shared unit finished outside a wait state");

endmodule

`default_nettype wire

### rtl/core/pvr_ram.sv
// ----------------------------------------------------------------------------
// pvr_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/pvr_iter_unit.sv
// ----------------------------------------------------------------------------
// pvr_iter_unit: shared shift / compare / subtract unit
// Floored square root (two radicand bits a step) or restoring division
// (one dividend bit a step) through one remainder datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pvr_iter_unit #(
    parameter int DIV_W = 21,
    parameter int DVS_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pvr_pkg::t_iter_cmd          i_cmd,
    input  logic [pvr_pkg::SQ_W-1:0]    i_radicand,
    input  logic [DIV_W-1:0]            i_dividend,
    input  logic [DVS_W-1:0]            i_divisor,
    output pvr_pkg::t_iter_sts          o_sts,
    output logic [pvr_pkg::ROOT_W-1:0]  o_result
);

    localparam int DW  = (DIV_W > pvr_pkg::SQ_W) ? DIV_W : pvr_pkg::SQ_W;
    localparam int RW  = (DVS_W + 1 > pvr_pkg::ROOT_W + 4) ? DVS_W + 1
                                                           : pvr_pkg::ROOT_W + 4;
    localparam int SCW = $clog2(DW + 1);

    logic                      r_busy;
    logic                      r_done;
    pvr_pkg::t_iter_op         r_op;
    logic [DW-1:0]             r_opnd;
    logic [RW-1:0]             r_rem;
    logic [pvr_pkg::ROOT_W-1:0] r_res;
    logic [DVS_W-1:0]          r_dvs;
    logic [SCW-1:0]            r_step;

    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          fits;

    always_comb begin
        if (r_op == pvr_pkg::ITER_SQRT) begin
            shifted = {r_rem[RW-3:0], r_opnd[DW-1:DW-2]};
            trial   = RW'({r_res, 2'b01});
        end else begin
            shifted = {r_rem[RW-2:0], r_opnd[DW-1]};
            trial   = RW'(r_dvs);
        end
        fits = (shifted >= trial);
        diff = shifted - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem  <= fits ? diff : shifted;
                r_res  <= {r_res[pvr_pkg::ROOT_W-2:0], fits};
                r_opnd <= (r_op == pvr_pkg::ITER_SQRT) ? (r_opnd << 2) : (r_opnd << 1);
                r_step <= r_step - SCW'(1);
                if (r_step == SCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_rem  <= '0;
                r_res  <= '0;
                r_dvs  <= i_divisor;
                if (i_cmd.op == pvr_pkg::ITER_SQRT) begin
                    r_opnd <= DW'(i_radicand) << (DW - pvr_pkg::SQ_W);
                    r_step <= SCW'(pvr_pkg::ROOT_W);
                end else begin
                    r_opnd <= DW'(i_dividend) << (DW - DIV_W);
                    r_step <= SCW'(DIV_W);
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_res;

endmodule

`default_nettype wire
